### src/cbe_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier easing package
// Request and result types, controller states, datapath operations and the
// fixed constants shared by the easing unit.
// ----------------------------------------------------------------------------
package cbe_pkg;

  typedef struct packed {
    logic signed [18:0] time_in;
    logic [6:0]         ctrl_x1;
    logic [6:0]         ctrl_y1;
    logic [6:0]         ctrl_x2;
    logic [6:0]         ctrl_y2;
  } cbe_req_t;

  typedef struct packed {
    logic [16:0] eased_value;
    logic [16:0] curve_param;
  } cbe_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UU,
    ST_TT,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_DIFF,
    ST_STEP,
    ST_YSCALE,
    ST_YDIV,
    ST_EMIT
  } cbe_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UU,
    OP_TT,
    OP_W1,
    OP_W2,
    OP_W3,
    OP_A1,
    OP_A2,
    OP_A3,
    OP_DIFF,
    OP_STEP,
    OP_YSCALE,
    OP_YDIV,
    OP_EMIT
  } cbe_op_t;

  typedef struct packed {
    cbe_op_t op;
    logic    use_y;
  } cbe_cmd_t;

  typedef struct packed {
    logic close;
    logic out_busy;
  } cbe_status_t;

  localparam int          TOL_UNITS  = 83;
  localparam int          CODE_SCALE = 127;
  localparam logic [24:0] RECIP_127  = 25'd16909320;
  localparam int          RECIP_SH   = 31;
  localparam logic [16:0] Q16_ONE    = 17'd65536;

endpackage

### src/cbe_ctrl.sv
// ----------------------------------------------------------------------------
// Cubic Bezier easing controller
// Sequences the curve evaluation steps, the bisection iterations and the
// final eased value pass, and handles the request handshake.
// ----------------------------------------------------------------------------
module cbe_ctrl import cbe_pkg::*; #(
  parameter int ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  cbe_status_t status,
  output cbe_cmd_t    cmd
);

  localparam int ITER_W = $clog2(ITERATIONS);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITERATIONS - 1);

  cbe_state_t        state;
  cbe_state_t        state_next;
  logic [ITER_W-1:0] iter;
  logic              ypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
      ypass <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && req_valid) begin
        iter  <= '0;
        ypass <= 1'b0;
      end else if (state == ST_STEP) begin
        if (status.close || iter == LAST_ITER) begin
          ypass <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_UU;
      ST_UU:     state_next = ST_TT;
      ST_TT:     state_next = ST_W1;
      ST_W1:     state_next = ST_W2;
      ST_W2:     state_next = ST_W3;
      ST_W3:     state_next = ST_A1;
      ST_A1:     state_next = ST_A2;
      ST_A2:     state_next = ST_A3;
      ST_A3:     state_next = ypass ? ST_YSCALE : ST_DIFF;
      ST_DIFF:   state_next = ST_STEP;
      ST_STEP:   state_next = ST_UU;
      ST_YSCALE: state_next = ST_YDIV;
      ST_YDIV:   state_next = ST_EMIT;
      ST_EMIT:   if (!status.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE);
    cmd.use_y = ypass;
    unique case (state)
      ST_IDLE:   cmd.op = req_valid ? OP_LOAD : OP_NONE;
      ST_UU:     cmd.op = OP_UU;
      ST_TT:     cmd.op = OP_TT;
      ST_W1:     cmd.op = OP_W1;
      ST_W2:     cmd.op = OP_W2;
      ST_W3:     cmd.op = OP_W3;
      ST_A1:     cmd.op = OP_A1;
      ST_A2:     cmd.op = OP_A2;
      ST_A3:     cmd.op = OP_A3;
      ST_DIFF:   cmd.op = OP_DIFF;
      ST_STEP:   cmd.op = OP_STEP;
      ST_YSCALE: cmd.op = OP_YSCALE;
      ST_YDIV:   cmd.op = OP_YDIV;
      ST_EMIT:   cmd.op = status.out_busy ? OP_NONE : OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

### src/cbe_dp.sv
// ----------------------------------------------------------------------------
// Cubic Bezier easing datapath
// One shared multiplier evaluates the Bernstein terms and the weighted sum,
// a subtractor forms the bisection error, and a reciprocal multiply with a
// one-step correction scales the eased value into Q16.
// ----------------------------------------------------------------------------
module cbe_dp import cbe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cbe_cmd_t    cmd,
  output cbe_status_t status,
  input  cbe_req_t    req_data,
  output logic        res_valid,
  input  logic        res_stall,
  output cbe_res_t    res_data
);

  localparam int F      = FRAC_BITS;
  localparam int TW     = F + 1;
  localparam int PW     = 2 * TW;
  localparam int SW     = F + 10;
  localparam int DW     = F + 27;
  localparam int NW     = SW + 17;
  localparam int MW     = 24;
  localparam int QW     = 18;
  localparam int RS     = (F > 16) ? (F - 16) : 0;
  localparam int LS     = (F < 16) ? (16 - F) : 0;
  localparam int TQW    = TW + LS + 1;
  localparam int HALF_T = (1 << RS) >> 1;

  localparam logic [TW-1:0]        ONE_T    = {1'b1, {F{1'b0}}};
  localparam logic [TW-1:0]        HALF_ONE = {2'b01, {(F - 1){1'b0}}};
  localparam logic signed [DW-1:0] TOL_POS  = DW'(TOL_UNITS) << F;
  localparam logic signed [DW-1:0] TOL_NEG  = -TOL_POS;
  localparam logic [NW-1:0]        HALF_DEN = NW'(CODE_SCALE) << (F - 1);

  logic [DW-2:0]        target;
  logic [8:0]           px1;
  logic [8:0]           px2;
  logic [8:0]           py1;
  logic [8:0]           py2;
  logic [TW-1:0]        t_cur;
  logic [TW-1:0]        lo;
  logic [TW-1:0]        hi;
  logic [TW-1:0]        uu;
  logic [TW-1:0]        tt;
  logic [TW-1:0]        w1;
  logic [TW-1:0]        w2;
  logic [TW-1:0]        w3;
  logic [SW-1:0]        acc;
  logic signed [DW-1:0] d;
  logic [MW-1:0]        m;
  logic [QW-1:0]        qe;

  logic [TW-1:0]        u;
  logic [TW-1:0]        mul_a;
  logic [TW-1:0]        mul_b;
  logic [PW-1:0]        prod;
  logic [TW-1:0]        prod_f;
  logic [TW-1:0]        lo_n;
  logic [TW-1:0]        hi_n;
  logic [TW:0]          mid_sum;
  logic [16:0]          tc;
  logic [23:0]          tc127;
  logic [NW-1:0]        n_sum;
  logic [MW+24:0]       qprod;
  logic [24:0]          qe127;
  logic [24:0]          rem;
  logic [QW-1:0]        q_fix;
  logic [16:0]          yq;
  logic [TQW-1:0]       tq_sum;
  logic [TQW-1:0]       tq_w;
  logic [16:0]          tq;
  logic [8:0]           coef_a;
  logic [8:0]           coef_b;

  assign u      = ONE_T - t_cur;
  assign coef_a = cmd.use_y ? py1 : px1;
  assign coef_b = cmd.use_y ? py2 : px2;

  always_comb begin
    case (cmd.op)
      OP_UU: begin
        mul_a = u;
        mul_b = u;
      end
      OP_TT: begin
        mul_a = t_cur;
        mul_b = t_cur;
      end
      OP_W1: begin
        mul_a = uu;
        mul_b = t_cur;
      end
      OP_W2: begin
        mul_a = u;
        mul_b = tt;
      end
      OP_W3: begin
        mul_a = tt;
        mul_b = t_cur;
      end
      OP_A1: begin
        mul_a = w1;
        mul_b = TW'(coef_a);
      end
      OP_A2: begin
        mul_a = w2;
        mul_b = TW'(coef_b);
      end
      OP_A3: begin
        mul_a = w3;
        mul_b = TW'(CODE_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_f = prod[F +: TW];

  assign status.close    = (d < TOL_POS) && (d > TOL_NEG);
  assign status.out_busy = res_valid && res_stall;

  always_comb begin
    lo_n = lo;
    hi_n = hi;
    if (d[DW-1]) begin
      hi_n = t_cur;
    end else begin
      lo_n = t_cur;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_comb begin
    if (req_data.time_in[18]) begin
      tc = '0;
    end else if (req_data.time_in[17:0] > 18'(Q16_ONE)) begin
      tc = Q16_ONE;
    end else begin
      tc = req_data.time_in[16:0];
    end
    tc127 = {tc, 7'b0} - {7'b0, tc};
  end

  assign n_sum = {1'b0, acc, 16'h0000} + HALF_DEN;
  assign qprod = m * RECIP_127;

  always_comb begin
    qe127 = {qe, 7'b0} - {7'b0, qe};
    rem   = {1'b0, m} - qe127;
    q_fix = (rem >= 25'(CODE_SCALE)) ? qe + 1'b1 : qe;
    yq    = (q_fix > QW'(Q16_ONE)) ? Q16_ONE : q_fix[16:0];
  end

  always_comb begin
    tq_sum = (TQW'(t_cur) << LS) + TQW'(HALF_T);
    tq_w   = tq_sum >> RS;
    tq     = (tq_w > TQW'(Q16_ONE)) ? Q16_ONE : tq_w[16:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        target <= {2'b00, tc127, {F{1'b0}}};
        px1    <= {req_data.ctrl_x1, 1'b0} + {2'b00, req_data.ctrl_x1};
        px2    <= {req_data.ctrl_x2, 1'b0} + {2'b00, req_data.ctrl_x2};
        py1    <= {req_data.ctrl_y1, 1'b0} + {2'b00, req_data.ctrl_y1};
        py2    <= {req_data.ctrl_y2, 1'b0} + {2'b00, req_data.ctrl_y2};
        lo     <= '0;
        hi     <= ONE_T;
        t_cur  <= HALF_ONE;
      end
      OP_UU:  uu  <= prod_f;
      OP_TT:  tt  <= prod_f;
      OP_W1:  w1  <= prod_f;
      OP_W2:  w2  <= prod_f;
      OP_W3:  w3  <= prod_f;
      OP_A1:  acc <= prod[SW-1:0];
      OP_A2:  acc <= acc + prod[SW-1:0];
      OP_A3:  acc <= acc + prod[SW-1:0];
      OP_DIFF: begin
        d <= $signed({1'b0, target}) - $signed({1'b0, acc, 16'h0000});
      end
      OP_STEP: begin
        if (!status.close) begin
          lo    <= lo_n;
          hi    <= hi_n;
          t_cur <= mid_sum[TW:1];
        end
      end
      OP_YSCALE: m  <= n_sum[F +: MW];
      OP_YDIV:   qe <= qprod[RECIP_SH +: QW];
      OP_EMIT: begin
        res_data.eased_value <= yq;
        res_data.curve_param <= tq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

### src/cubic_bezier_easing_unit.sv
// ----------------------------------------------------------------------------
// Cubic Bezier easing unit
// Clamps a Q16 time, finds the curve parameter whose x matches it by
// bisection, and returns that parameter and the curve y, both in Q16.
//
//   Channel  Signals                        Carries
//   req      req_valid, req_stall, req_data time and four control codes
//   res      res_valid, res_stall, res_data eased value and curve parameter
//
// A request runs k bisection steps, where k is 1 to ITERATIONS; each step
// is eight passes through the shared multiplier plus an error subtract and
// an update. A final y pass, the scaling and the correction follow them.
// The unit stalls new requests until the current one has been emitted.
// Reset clears the controller and the result valid flag.
// A stalled result does not block the next request until a second result is
// ready to be written.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_unit import cbe_pkg::*; #(
  parameter int ITERATIONS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  cbe_req_t req_data,
  output logic     res_valid,
  input  logic     res_stall,
  output cbe_res_t res_data
);

  cbe_cmd_t    cmd;
  cbe_status_t status;

  cbe_ctrl #(
    .ITERATIONS(ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cbe_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
